@@ src/json_top_level_key_extractor_macros.svh @@
// Assertion macros used by the key extractor top level.
`ifndef JSON_TOP_LEVEL_KEY_EXTRACTOR_MACROS_SVH
`define JSON_TOP_LEVEL_KEY_EXTRACTOR_MACROS_SVH

// Checked on every clock edge outside reset.
`define JTKE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define JTKE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/jtke_pkg.sv @@
package jtke_pkg;

    localparam int KEY_MAX_DEFAULT     = 16;
    localparam int TOKEN_LIMIT_DEFAULT = 63;

    localparam int CFG_WIDTH     = 64;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int KEY_LEN_WIDTH = 5;
    localparam int KEY_CHARS     = 16;
    localparam int COUNT_WIDTH   = 6;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_FOUND   = 2'd1;
    localparam logic [1:0] KIND_MISSING = 2'd2;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    localparam logic signed [7:0] LEVEL_LIMIT = 8'sd127;
    localparam logic signed [7:0] TOP_BRACE   = 8'sd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic [1:0] result_kind;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic signed [7:0]      brace_level;
        logic signed [7:0]      bracket_level;
        logic [COUNT_WIDTH-1:0] token_count;
        logic                   token_differs;
        logic                   key_matched;
        logic                   text_finished;
    } scan_state_t;

    typedef struct packed {
        logic      have;
        out_item_t item;
    } scan_result_t;

    function automatic logic signed [7:0] level_inc(input logic signed [7:0] level);
        level_inc = (level == LEVEL_LIMIT) ? level : level + 8'sd1;
    endfunction

    function automatic logic signed [7:0] level_dec(input logic signed [7:0] level);
        level_dec = (level == -LEVEL_LIMIT) ? level : level - 8'sd1;
    endfunction

endpackage

@@ src/jtke_scan.sv @@
module jtke_scan import jtke_pkg::*; #(
    parameter int KEY_MAX     = KEY_MAX_DEFAULT,
    parameter int TOKEN_LIMIT = TOKEN_LIMIT_DEFAULT
) (
    input  scan_state_t              state,
    input  in_item_t                 item,
    input  logic [CFG_WIDTH-1:0]     key_low,
    input  logic [CFG_WIDTH-1:0]     key_high,
    input  logic [KEY_LEN_WIDTH-1:0] key_length,
    output scan_state_t              state_next,
    output scan_result_t             result
);

    localparam logic [COUNT_WIDTH-1:0] KeyMaxC     = COUNT_WIDTH'(KEY_MAX);
    localparam logic [COUNT_WIDTH-1:0] TokenLimitC = COUNT_WIDTH'(TOKEN_LIMIT);
    localparam logic [COUNT_WIDTH-1:0] KeyCharsC   = COUNT_WIDTH'(KEY_CHARS);

    logic [KEY_CHARS-1:0][7:0] key_chars;
    logic [COUNT_WIDTH-1:0]    key_len_used;
    logic [7:0]                key_char;

    assign key_chars = {key_high, key_low};

    always_comb
    begin
        if ({1'b0, key_length} > KeyMaxC)
            key_len_used = KeyMaxC;
        else
            key_len_used = {1'b0, key_length};
    end

    // Key positions past the held characters compare against zero.
    assign key_char = (state.token_count < KeyCharsC)
                      ? key_chars[state.token_count[3:0]] : 8'd0;

    always_comb
    begin
        logic [7:0] b;
        logic       top;
        logic       found;
        logic       emit;

        b          = item.text_byte;
        top        = 1'b0;
        found      = 1'b0;
        emit       = 1'b0;
        state_next = state;
        result     = '0;

        if (!state.text_finished)
        begin
            unique case (b)
                CH_LBRACE:   state_next.brace_level   = level_inc(state.brace_level);
                CH_RBRACE:   state_next.brace_level   = level_dec(state.brace_level);
                CH_LBRACKET: state_next.bracket_level = level_inc(state.bracket_level);
                CH_RBRACKET: state_next.bracket_level = level_dec(state.bracket_level);
                default:     ;
            endcase

            top = (state_next.brace_level < TOP_BRACE) && (state_next.bracket_level == 8'sd0);

            if (top)
            begin
                if (b == CH_COLON || b == CH_COMMA || b == CH_RBRACE)
                begin
                    if (state.key_matched)
                        found = 1'b1;
                    else
                    begin
                        if (!state.token_differs && state.token_count == key_len_used)
                            state_next.key_matched = 1'b1;
                        state_next.token_count   = '0;
                        state_next.token_differs = 1'b0;
                    end
                end
                else if (b != CH_QUOTE && b != CH_LBRACE && b != CH_SPACE)
                begin
                    if (state.token_count < TokenLimitC)
                    begin
                        if (state.key_matched)
                            emit = 1'b1;
                        else if (state.token_count >= key_len_used || key_char != b)
                            state_next.token_differs = 1'b1;
                        state_next.token_count = state.token_count + 1'b1;
                    end
                end
            end

            // A completed value wins over the end of the text.
            priority if (found)
            begin
                result.have             = 1'b1;
                result.item.result_kind = KIND_FOUND;
                result.item.run_last    = 1'b1;
                state_next.text_finished = 1'b1;
            end
            else if (item.end_of_text)
            begin
                result.have             = 1'b1;
                result.item.result_kind = KIND_MISSING;
                result.item.run_last    = 1'b1;
            end
            else if (emit)
            begin
                result.have             = 1'b1;
                result.item.value_byte  = b;
                result.item.result_kind = KIND_CHAR;
            end
            else
                result.have = 1'b0;
        end

        if (item.end_of_text)
            state_next = '0;
    end

endmodule

@@ src/json_top_level_key_extractor.sv @@
// Channel | Direction | Handshake          | Payload
// cfg     | in        | cfg_write          | cfg_index, cfg_data
// in      | in        | in_valid, in_stall | in_item (text_byte, end_of_text)
// out     | out       | out_valid, out_stall | out_item (value_byte, result_kind, run_last)
//
// One text byte is taken per cycle unless in_stall is high; any result is registered.
// Scan state and result (or skid) register update in the same cycle the item is accepted.
// A two-entry output buffer (result register plus skid register) lets the input run on
// while one result waits; in_stall rises only when both entries are full.
// Reset clears the scan state, the key registers and both output entries; no clearing pass.
module json_top_level_key_extractor import jtke_pkg::*; #(
    parameter int KEY_MAX     = KEY_MAX_DEFAULT,
    parameter int TOKEN_LIMIT = TOKEN_LIMIT_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_item_t                 in_item,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_item
);

`include "json_top_level_key_extractor_macros.svh"

    logic [CFG_WIDTH-1:0]     key_low_reg;
    logic [CFG_WIDTH-1:0]     key_high_reg;
    logic [KEY_LEN_WIDTH-1:0] key_length_reg;

    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t scan_res;

    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      skid_valid_reg;
    out_item_t skid_item_reg;

    logic in_fire;
    logic out_fire;
    logic main_free;

    jtke_scan #(
        .KEY_MAX     (KEY_MAX),
        .TOKEN_LIMIT (TOKEN_LIMIT)
    ) u_scan (
        .state      (state_reg),
        .item       (in_item),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .key_length (key_length_reg),
        .state_next (state_next),
        .result     (scan_res)
    );

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign main_free = !out_valid_reg || out_fire;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_reg    <= cfg_data;
                CFG_KEY_HIGH: key_high_reg   <= cfg_data;
                CFG_KEY_LEN:  key_length_reg <= cfg_data[KEY_LEN_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_fire)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (main_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire && scan_res.have)
        begin
            if (main_free)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (main_free)
                out_item_reg <= skid_item_reg;
        end
        else if (in_fire && scan_res.have)
        begin
            if (main_free)
                out_item_reg <= scan_res.item;
            else
                skid_item_reg <= scan_res.item;
        end
    end

    `JTKE_ASSERT_ALWAYS(a_skid_behind_main, skid_valid_reg |-> out_valid_reg, "skid full while result register empty")
    `JTKE_ASSERT(a_quiet_after_result, state_reg.text_finished |-> !scan_res.have, "result after text finished")
    `JTKE_ASSERT(a_run_last_kind, out_valid_reg |-> ((out_item_reg.result_kind == KIND_CHAR) == !out_item_reg.run_last), "run_last does not match result kind")
    `JTKE_ASSERT(a_level_range, state_reg.brace_level != 8'sh80 && state_reg.bracket_level != 8'sh80, "nesting level out of range")
    `JTKE_ASSERT(a_eot_clears, (in_fire && in_item.end_of_text) |=> state_reg == '0, "state not cleared at end of text")

endmodule
